// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the pooling block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

// ----- rtl/mp2d_pkg.sv -----
// Shared types, constants and fp32 compare helpers for the max pooling block.
package mp2d_pkg;

  localparam int MAX_IMAGE_WIDTH_DEF = 256;
  localparam int MAX_WINDOW_DEF      = 8;
  localparam int DIV_STEPS           = 16;

  localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;

  // Register indexes on the config port
  localparam logic [2:0] REG_CHANNELS    = 3'd0;
  localparam logic [2:0] REG_HEIGHT      = 3'd1;
  localparam logic [2:0] REG_WIDTH       = 3'd2;
  localparam logic [2:0] REG_WIN_ROWS    = 3'd3;
  localparam logic [2:0] REG_WIN_COLS    = 3'd4;
  localparam logic [2:0] REG_STRIDE_ROWS = 3'd5;
  localparam logic [2:0] REG_STRIDE_COLS = 3'd6;

  // Divide operations, in sequencer order
  localparam logic [1:0] DIV_OROW = 2'd0;
  localparam logic [1:0] DIV_OCOL = 2'd1;
  localparam logic [1:0] DIV_HQ   = 2'd2;
  localparam logic [1:0] DIV_WQ   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] x);
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  // IEEE a > b on bit patterns
  function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
    logic res;
    res = 1'b0;
    if (!is_nan(a) && !is_nan(b) && !(a[30:0] == 31'd0 && b[30:0] == 31'd0))
      res = order_key(a) > order_key(b);
    return res;
  endfunction

  // Stride phase advance
  function automatic logic [7:0] next_phase(input logic [7:0] ph, input logic [7:0] stride);
    logic [8:0] inc;
    inc = {1'b0, ph} + 9'd1;
    return (inc >= {1'b0, stride}) ? 8'd0 : inc[7:0];
  endfunction

endpackage

// ----- rtl/mp2d_ram.sv -----
// Generic single write, single read RAM with registered read data.
module mp2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/max_pool_2d_stream.sv -----
// Streaming 2-D max pooling of fp32 samples: top level with sequencer and datapath.
//
// Input stream s_*: one fp32 sample per request, channel-major raster order
// (channel, row, column). Output stream m_*: one pooled result per window,
// tdata = {out_col, out_row, out_channel, pooled_max}, tlast = plane_last.
// The user must set geometry over the APB port only while idle; it is not enforced.
//
// A sample that closes no window leaves the block idle; s_tready stays high.
// A sample that closes a window starts a walk: the line store is read one word
// per cycle through a single fp32 comparator, then one shared restoring divider
// produces output row, column and plane extents in turn. s_tready is low through
// the walk, drain, divide and done states.
// The result sits in an output register; the block goes on taking samples
// while it waits. If the receiver stalls and a new result is ready, the
// block holds until the register frees.
// Reset (synchronous, rst) clears counters and handshake state and sets all
// config registers to 1. The line store is not cleared.
module max_pool_2d_stream
  import mp2d_pkg::*;
#(
  parameter int MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_WINDOW      = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] pooled_max, [47:32] out_channel,
                                 // [63:48] out_row, [71:64] out_col
  output logic        m_tlast,   // plane_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW    = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
  localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEPTH = MAX_WINDOW * MAX_IMAGE_WIDTH;
  localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

  // Config registers
  logic [15:0] cfg_channels, cfg_height;
  logic [8:0]  cfg_width;
  logic [3:0]  cfg_win_rows, cfg_win_cols;
  logic [7:0]  cfg_stride_rows, cfg_stride_cols;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_channels    <= 16'd1;
      cfg_height      <= 16'd1;
      cfg_width       <= 9'd1;
      cfg_win_rows    <= 4'd1;
      cfg_win_cols    <= 4'd1;
      cfg_stride_rows <= 8'd1;
      cfg_stride_cols <= 8'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_CHANNELS:    cfg_channels    <= pwdata[15:0];
        REG_HEIGHT:      cfg_height      <= pwdata[15:0];
        REG_WIDTH:       cfg_width       <= pwdata[8:0];
        REG_WIN_ROWS:    cfg_win_rows    <= pwdata[3:0];
        REG_WIN_COLS:    cfg_win_cols    <= pwdata[3:0];
        REG_STRIDE_ROWS: cfg_stride_rows <= pwdata[7:0];
        REG_STRIDE_COLS: cfg_stride_cols <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_CHANNELS:    prdata = {16'd0, cfg_channels};
      REG_HEIGHT:      prdata = {16'd0, cfg_height};
      REG_WIDTH:       prdata = {23'd0, cfg_width};
      REG_WIN_ROWS:    prdata = {28'd0, cfg_win_rows};
      REG_WIN_COLS:    prdata = {28'd0, cfg_win_cols};
      REG_STRIDE_ROWS: prdata = {24'd0, cfg_stride_rows};
      REG_STRIDE_COLS: prdata = {24'd0, cfg_stride_cols};
      default:         prdata = 32'd0;
    endcase
  end

  // Normalized geometry
  logic [15:0] c_n, h_n, w_raw, w_n;
  logic [15:0] p16, q16;
  logic        enabled;

  assign c_n   = (cfg_channels == 16'd0) ? 16'd1 : cfg_channels;
  assign h_n   = (cfg_height == 16'd0) ? 16'd1 : cfg_height;
  assign w_raw = (cfg_width == 9'd0) ? 16'd1 : {7'd0, cfg_width};
  assign w_n   = (w_raw > 16'(MAX_IMAGE_WIDTH)) ? 16'(MAX_IMAGE_WIDTH) : w_raw;
  assign p16   = {12'd0, cfg_win_rows};
  assign q16   = {12'd0, cfg_win_cols};
  assign enabled = (p16 != 16'd0) && (q16 != 16'd0) &&
                   (p16 <= 16'(MAX_WINDOW)) && (q16 <= 16'(MAX_WINDOW)) &&
                   (cfg_stride_rows != 8'd0) && (cfg_stride_cols != 8'd0) &&
                   (h_n >= p16) && (w_n >= q16);

  // Position state
  state_t      state, state_next;
  logic [15:0] row_count, channel_count;
  logic [CW-1:0] col_count;
  logic [7:0]  row_phase, col_phase;
  logic [SW-1:0] row_slot;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(MAX_WINDOW - 1)) ? SW'(0) : s + SW'(1);
  endfunction

  // Wrap of counters before the sample is placed
  logic        col_wrap, row_wrap;
  logic [15:0] r0, r1, ch0, ch1;
  logic [CW-1:0] c0;
  logic [7:0]  cph0, rph0;
  logic [SW-1:0] slot0, slot1;

  always_comb begin
    col_wrap = {{(16-CW){1'b0}}, col_count} >= w_n;
    r0    = col_wrap ? row_count + 16'd1 : row_count;
    c0    = col_wrap ? CW'(0) : col_count;
    cph0  = col_wrap ? 8'd0 : col_phase;
    slot0 = col_wrap ? slot_inc(row_slot) : row_slot;
    row_wrap = r0 >= h_n;
    r1    = row_wrap ? 16'd0 : r0;
    rph0  = row_wrap ? 8'd0 : row_phase;
    slot1 = row_wrap ? SW'(0) : slot0;
    ch0   = row_wrap ? channel_count + 16'd1 : channel_count;
    ch1   = (ch0 >= c_n) ? 16'd0 : ch0;
  end

  // Window close check
  logic [16:0]   r_inc;
  logic [CW:0]   c_inc;
  logic          emit_now;
  logic [15:0]   top_now;
  logic [CW-1:0] left_now;
  logic [SW:0]   tslot_sum;
  logic [SW-1:0] tslot_now;

  always_comb begin
    r_inc    = {1'b0, r1} + 17'd1;
    c_inc    = {1'b0, c0} + (CW+1)'(1);
    emit_now = enabled && (r_inc >= {1'b0, p16}) && (17'(c_inc) >= {1'b0, q16}) &&
               (rph0 == 8'd0) && (cph0 == 8'd0);
    top_now  = 16'(r_inc - {1'b0, p16});
    left_now = CW'(c_inc - (CW+1)'(cfg_win_cols));
    tslot_sum = {1'b0, slot1} + (SW+1)'(MAX_WINDOW) - (SW+1)'(cfg_win_rows - 4'd1);
    tslot_now = (tslot_sum >= (SW+1)'(MAX_WINDOW)) ?
                SW'(tslot_sum - (SW+1)'(MAX_WINDOW)) : SW'(tslot_sum);
  end

  // Position advance after the sample
  logic [15:0]   row_next, channel_next;
  logic [CW-1:0] col_next;
  logic [7:0]    row_phase_next, col_phase_next;
  logic [SW-1:0] row_slot_next;
  logic [15:0]   ch_inc;

  always_comb begin
    ch_inc         = ch1 + 16'd1;
    col_phase_next = ((17'(c_inc) >= {1'b0, q16}) && (q16 != 16'd0)) ?
                     next_phase(cph0, cfg_stride_cols) : cph0;
    col_next       = c_inc[CW-1:0];
    row_phase_next = rph0;
    row_next       = r1;
    row_slot_next  = slot1;
    channel_next   = ch1;
    if (16'(c_inc) >= w_n) begin
      col_next       = CW'(0);
      col_phase_next = 8'd0;
      if ((r_inc >= {1'b0, p16}) && (p16 != 16'd0))
        row_phase_next = next_phase(rph0, cfg_stride_rows);
      if (r_inc >= {1'b0, h_n}) begin
        row_next       = 16'd0;
        row_phase_next = 8'd0;
        row_slot_next  = SW'(0);
        channel_next   = (ch_inc >= c_n) ? 16'd0 : ch_inc;
      end else begin
        row_next      = r_inc[15:0];
        row_slot_next = slot_inc(slot1);
      end
    end
  end

  logic s_accept;
  assign s_accept = s_tvalid && s_tready;

  // Line store
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_q;

  // Window walk and divider registers
  logic [3:0]    walk_i, walk_j;
  logic [SW-1:0] walk_slot;
  logic          rd_pending;
  logic [31:0]   best;
  logic [15:0]   item_ch, item_top;
  logic [CW-1:0] item_left;
  logic [1:0]    div_op;
  logic [4:0]    div_cnt;
  logic [15:0]   div_num;
  logic [7:0]    div_rem, div_den;
  logic [15:0]   orow, ocol, hq, wq;
  logic          out_valid;
  logic [31:0]   out_max;
  logic [15:0]   out_ch, out_row;
  logic [7:0]    out_col;
  logic          out_last;

  logic walk_last_col, walk_last;
  assign walk_last_col = (walk_j == cfg_win_cols - 4'd1);
  assign walk_last     = walk_last_col && (walk_i == cfg_win_rows - 4'd1);

  assign ram_waddr = AW'(slot1) * AW'(MAX_IMAGE_WIDTH) + AW'(c0);
  assign ram_raddr = AW'(walk_slot) * AW'(MAX_IMAGE_WIDTH) + AW'(item_left) + AW'(walk_j);

  mp2d_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (s_accept),
    .waddr(ram_waddr),
    .wdata(s_tdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // Divider step
  logic [8:0]  div_sh;
  logic        div_ge;
  logic [7:0]  div_rem_step;
  logic [15:0] div_num_step;
  logic [15:0] div_load_num;
  logic [7:0]  div_load_den;
  logic        div_fin;

  always_comb begin
    div_sh       = {div_rem, div_num[15]};
    div_ge       = div_sh >= {1'b0, div_den};
    div_rem_step = div_ge ? 8'(div_sh - {1'b0, div_den}) : div_sh[7:0];
    div_num_step = {div_num[14:0], div_ge};
    div_fin      = (div_cnt == 5'(DIV_STEPS));
    unique case (div_op)
      DIV_OROW: div_load_num = item_top;
      DIV_OCOL: div_load_num = 16'(item_left);
      DIV_HQ:   div_load_num = h_n - p16;
      DIV_WQ:   div_load_num = w_n - q16;
      default:  div_load_num = 16'd0;
    endcase
    div_load_den = div_op[0] ? cfg_stride_cols : cfg_stride_rows;
  end

  logic out_free;
  assign out_free = !out_valid || m_tready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && emit_now) state_next = ST_WALK;
      end
      ST_WALK:  if (walk_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DIV;
      ST_DIV:   if (div_fin && div_op == DIV_WQ) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= 16'd0;
      col_count     <= CW'(0);
      channel_count <= 16'd0;
      row_phase     <= 8'd0;
      col_phase     <= 8'd0;
      row_slot      <= SW'(0);
    end else if (s_accept) begin
      row_count     <= row_next;
      col_count     <= col_next;
      channel_count <= channel_next;
      row_phase     <= row_phase_next;
      col_phase     <= col_phase_next;
      row_slot      <= row_slot_next;
    end
  end

  // Walk, compare and divide datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      walk_i     <= 4'd0;
      walk_j     <= 4'd0;
      div_op     <= DIV_OROW;
      div_cnt    <= 5'd0;
    end else begin
      if (rd_pending && fp_greater(ram_q, best))
        best <= ram_q;
      unique case (state)
        ST_IDLE: begin
          rd_pending <= 1'b0;
          if (s_accept && emit_now) begin
            item_ch   <= ch1;
            item_top  <= top_now;
            item_left <= left_now;
            walk_slot <= tslot_now;
            walk_i    <= 4'd0;
            walk_j    <= 4'd0;
            best      <= NEG_INF_BITS;
          end
        end
        ST_WALK: begin
          rd_pending <= 1'b1;
          if (walk_last_col) begin
            walk_j    <= 4'd0;
            walk_i    <= walk_i + 4'd1;
            walk_slot <= slot_inc(walk_slot);
          end else begin
            walk_j <= walk_j + 4'd1;
          end
          div_op  <= DIV_OROW;
          div_cnt <= 5'd0;
        end
        ST_DRAIN: rd_pending <= 1'b0;
        ST_DIV: begin
          if (div_cnt == 5'd0) begin
            div_num <= div_load_num;
            div_den <= div_load_den;
            div_rem <= 8'd0;
            div_cnt <= 5'd1;
          end else begin
            div_num <= div_num_step;
            div_rem <= div_rem_step;
            if (div_fin) begin
              unique case (div_op)
                DIV_OROW: orow <= div_num_step;
                DIV_OCOL: ocol <= div_num_step;
                DIV_HQ:   hq   <= div_num_step;
                DIV_WQ:   wq   <= div_num_step;
                default: ;
              endcase
              div_cnt <= 5'd0;
              div_op  <= div_op + 2'd1;
            end else begin
              div_cnt <= div_cnt + 5'd1;
            end
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
      out_max   <= best;
      out_ch    <= item_ch;
      out_row   <= orow;
      out_col   <= ocol[7:0];
      out_last  <= (orow == hq) && (ocol == wq);
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_col, out_row, out_ch, out_max};
  assign m_tlast  = out_last;

`include "assert_macros.svh"

  `ASSERT_AT(a_walk_range, (state != ST_WALK) || (walk_i < cfg_win_rows && walk_j < cfg_win_cols), "window walk index out of range")
  `ASSERT_NEXT(a_no_emit_idle, s_accept && !emit_now, state == ST_IDLE, "non-closing sample left idle")
  `ASSERT_NEXT(a_done_hold, state == ST_DONE && out_valid && !m_tready, state == ST_DONE && out_valid, "result overwrote pending output")
  `ASSERT_AT(a_div_cnt, div_cnt <= 5'(DIV_STEPS), "divider step count overrun")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the streaming 2-D max pooling block.
module tb_top;
  import mp2d_pkg::*;

  typedef struct packed {
    logic [31:0] maxv;
    logic [15:0] ch;
    logic [15:0] row;
    logic [7:0]  col;
    logic        last;
  } pool_res_t;

  // Scoreboard: tracks block geometry, predicts pooled windows, checks results
  class pool_scoreboard;
    bit [31:0]   lines [2048];
    int unsigned row_n, col_n, chan_n, row_ph, col_ph;
    int unsigned chans, height, width, win_r, win_c, str_r, str_c;
    pool_res_t   pending_q [$];
    int          errors;

    function new();
      foreach (lines[i]) lines[i] = 0;
      row_n = 0; col_n = 0; chan_n = 0; row_ph = 0; col_ph = 0;
      chans = 1; height = 1; width = 1; win_r = 1; win_c = 1; str_r = 1; str_c = 1;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_CHANNELS:    chans  = v[15:0];
        REG_HEIGHT:      height = v[15:0];
        REG_WIDTH:       width  = v[8:0];
        REG_WIN_ROWS:    win_r  = v[3:0];
        REG_WIN_COLS:    win_c  = v[3:0];
        REG_STRIDE_ROWS: str_r  = v[7:0];
        REG_STRIDE_COLS: str_c  = v[7:0];
        default: ;
      endcase
    endfunction

    function bit nan_bits(bit [31:0] x);
      return x[30:0] > 31'h7F80_0000;
    endfunction

    function bit [31:0] sort_key(bit [31:0] x);
      return x[31] ? ~x : {1'b1, x[30:0]};
    endfunction

    // strict IEEE greater-than
    function bit beats(bit [31:0] a, bit [31:0] b);
      if (nan_bits(a) || nan_bits(b)) return 0;
      if (a[30:0] == 0 && b[30:0] == 0) return 0;
      return sort_key(a) > sort_key(b);
    endfunction

    function int unsigned step_phase(int unsigned ph, int unsigned s);
      return (ph + 1 >= s) ? 0 : ph + 1;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // accepted input request: update state, queue the pooled result if one closes
    function void note_input(bit [31:0] s);
      int unsigned cn, hn, wn, top, left, hout, wout, orow, ocol;
      bit [31:0]   best, v;
      bit          on;
      pool_res_t   r;
      cn = chans ? chans : 1;
      hn = height ? height : 1;
      wn = width ? width : 1;
      if (wn > 256) wn = 256;
      if (col_n >= wn) begin col_n = 0; col_ph = 0; row_n++; end
      if (row_n >= hn) begin row_n = 0; row_ph = 0; chan_n++; end
      if (chan_n >= cn) chan_n = 0;
      lines[(row_n % 8) * 256 + col_n] = s;
      on = win_r >= 1 && win_c >= 1 && win_r <= 8 && win_c <= 8 && str_r != 0 &&
           str_c != 0 && hn >= win_r && wn >= win_c;
      if (on && row_n + 1 >= win_r && col_n + 1 >= win_c && row_ph == 0 && col_ph == 0) begin
        best = NEG_INF_BITS;
        top  = row_n + 1 - win_r;
        left = col_n + 1 - win_c;
        for (int i = 0; i < win_r; i++)
          for (int j = 0; j < win_c; j++) begin
            v = lines[((top + i) % 8) * 256 + left + j];
            if (beats(v, best)) best = v;
          end
        orow = top / str_r;
        ocol = left / str_c;
        hout = (hn - win_r) / str_r + 1;
        wout = (wn - win_c) / str_c + 1;
        r.maxv = best;
        r.ch   = chan_n[15:0];
        r.row  = orow[15:0];
        r.col  = ocol[7:0];
        r.last = (orow + 1 == hout && ocol + 1 == wout);
        pending_q.push_back(r);
      end
      if (col_n + 1 >= win_c && win_c >= 1) col_ph = step_phase(col_ph, str_c);
      col_n++;
      if (col_n >= wn) begin
        col_n = 0; col_ph = 0;
        if (row_n + 1 >= win_r && win_r >= 1) row_ph = step_phase(row_ph, str_r);
        row_n++;
        if (row_n >= hn) begin
          row_n = 0; row_ph = 0; chan_n++;
          if (chan_n >= cn) chan_n = 0;
        end
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check(pool_res_t got);
      pool_res_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", got.maxv, 32'd0);
      end else begin
        w = pending_q.pop_front();
        if (got.maxv !== w.maxv) report("pooled_max", got.maxv, w.maxv);
        if (got.ch !== w.ch) report("out_channel", 32'(got.ch), 32'(w.ch));
        if (got.row !== w.row) report("out_row", 32'(got.row), 32'(w.row));
        if (got.col !== w.col) report("out_col", 32'(got.col), 32'(w.col));
        if (got.last !== w.last) report("plane_last", 32'(got.last), 32'(w.last));
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;   // [31:0] sample
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;       // [31:0] max, [47:32] channel, [63:48] row, [71:64] col
  logic        m_tlast;       // plane_last
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  max_pool_2d_stream uut (.*);

  always #6 clk = ~clk;

  pool_scoreboard sb = new();
  int  burst_left = 0;
  int  sent = 0;
  bit  hold_tgl = 0;
  int  idle_cycles = 0;

  // receiver: result checks, stall pattern, long hold on request
  bit hold_seen = 0;
  int hold_cnt = 0;
  int rx_cyc = 0;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check({m_tdata[31:0], m_tdata[47:32], m_tdata[63:48], m_tdata[71:64], m_tlast});
    rx_cyc++;
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 0;
    end else begin
      case ((rx_cyc / 300) % 3)
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= (rx_cyc % 4 == 0);
      endcase
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("[max_pool_2d_stream] ERROR");
      $finish;
    end
  end

  // one register write; back-to-back writes go straight to the next setup cycle
  task apb_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // offer one sample; bursts with random gaps
  task send_sample(logic [31:0] x);
    s_tvalid <= 1;
    s_tdata <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(x);
    sent++;
    if (burst_left <= 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  function logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return {$urandom_range(0, 1) == 1, 31'h7F80_0000};
      2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      3: return $urandom_range(0, 1) ? 32'h3F80_0000 : 32'hBF80_0000;
      default: return $urandom;
    endcase
  endfunction

  // wait for the block to drain, then load a full geometry
  task set_geometry(int c, int h, int w, int p, int q, int sr, int sc);
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    apb_write(REG_CHANNELS, c);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_WIDTH, w);
    apb_write(REG_WIN_ROWS, p);
    apb_write(REG_WIN_COLS, q);
    apb_write(REG_STRIDE_ROWS, sr);
    apb_write(REG_STRIDE_COLS, sc);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task run_phase(int c, int h, int w, int p, int q, int sr, int sc, int n);
    set_geometry(c, h, w, p, q, sr, sc);
    repeat (n) send_sample(rand_sample());
  endtask

  logic [31:0] directed [12] = '{
    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'h0000_0000,
    32'h7F80_0001, 32'hFFC0_0000, 32'h8000_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF};

  initial begin
    int c, h, w, p, q, sr, sc;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // NaN-only window, signed zeros, infinities
    set_geometry(1, 2, 6, 2, 2, 1, 2);
    foreach (directed[i]) send_sample(directed[i]);

    run_phase(1, 8, 8, 8, 8, 1, 1, 64);        // largest window
    run_phase(1, 1, 256, 1, 8, 1, 255, 256);   // widest row, largest stride
    run_phase(1, 1, 511, 1, 1, 255, 1, 256);   // width saturates
    run_phase(0, 0, 0, 1, 1, 1, 1, 3);         // zero geometry acts as 1
    run_phase(2, 3, 4, 0, 9, 1, 1, 24);        // invalid window sizes
    run_phase(1, 4, 4, 15, 2, 1, 1, 16);
    run_phase(1, 4, 4, 2, 2, 0, 1, 16);        // zero strides
    run_phase(1, 4, 4, 2, 2, 1, 0, 16);
    run_phase(1, 3, 4, 4, 2, 1, 1, 12);        // window taller than image
    run_phase(65535, 2, 3, 2, 2, 1, 1, 12);
    run_phase(3, 65535, 4, 2, 2, 2, 1, 12);
    run_phase(1, 1, 1, 1, 1, 1, 1, 1);         // forces counters back to zero

    // long receiver hold while samples keep coming
    set_geometry(1, 6, 10, 2, 2, 1, 1);
    hold_tgl = ~hold_tgl;
    repeat (60) send_sample(rand_sample());

    // random geometries, whole frames each
    while (sent < 1550) begin
      c  = $urandom_range(1, 3);
      h  = $urandom_range(1, 10);
      w  = $urandom_range(1, 16);
      p  = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 3);
      q  = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 3);
      sr = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
      sc = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
      if (c * h * w > 200) c = 1;
      run_phase(c, h, w, p, q, sr, sc, c * h * w);
    end

    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[max_pool_2d_stream] OK");
    end else begin
      $display("[max_pool_2d_stream] ERROR");
    end
    $finish;
  end
endmodule

// ----- max_pool_2d_stream.f -----
+incdir+rtl
rtl/mp2d_pkg.sv
rtl/mp2d_ram.sv
rtl/max_pool_2d_stream.sv
sim/tb_top.sv
